/* rtl/dvmrp_pkg.sv */
// Shared types and constants for the DVMRP message parser.
package dvmrp_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [3:0] KIND_HEADER = 4'd0;
  localparam logic [3:0] KIND_GENID  = 4'd1;
  localparam logic [3:0] KIND_PNBR   = 4'd2;
  localparam logic [3:0] KIND_ROUTE  = 4'd3;
  localparam logic [3:0] KIND_NBR    = 4'd4;
  localparam logic [3:0] KIND_PRUNE  = 4'd5;
  localparam logic [3:0] KIND_GRAFT  = 4'd6;
  localparam logic [3:0] KIND_GACK   = 4'd7;
  localparam logic [3:0] KIND_TRUNC  = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [7:0]  message_type;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] lifetime;
    logic [7:0]  metric;
    logic [7:0]  threshold;
    logic [7:0]  neighbor_flags;
    logic        end_of_message;
  } record_t;

  // Up to two records per byte.
  typedef struct packed {
    logic    has_a;
    logic    has_b;
    record_t rec_a;
    record_t rec_b;
  } pair_t;

endpackage

/* rtl/dvmrp_front.sv */
// Byte parser: consumes one byte a cycle while take is high and forms up to two records.
module dvmrp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output dvmrp_pkg::pair_t     pair
);
  import dvmrp_pkg::*;

  localparam logic [3:0] S_HDR = 4'd0;
  localparam logic [3:0] S_SKIP = 4'd1;
  localparam logic [3:0] S_GENID = 4'd2;
  localparam logic [3:0] S_PNBR = 4'd3;
  localparam logic [3:0] S_MASK = 4'd4;
  localparam logic [3:0] S_ORIGIN = 4'd5;
  localparam logic [3:0] S_ENTRY = 4'd6;
  localparam logic [3:0] S_LIST = 4'd7;
  localparam logic [3:0] S_PRUNE = 4'd8;
  localparam logic [3:0] S_GRAFT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] header_position, header_position_next;
  logic [7:0] type_register, type_register_next;
  logic [15:0] version_bytes, version_bytes_next;
  logic [3:0] section_state, section_state_next;
  logic [3:0] byte_in_group, byte_in_group_next;
  logic [31:0] word_a, word_a_next, word_b, word_b_next, word_c, word_c_next;
  logic [2:0] origin_width, origin_width_next;
  logic [7:0] metric_byte, metric_byte_next, threshold_byte, threshold_byte_next;
  logic [7:0] flags_byte, flags_byte_next, neighbors_left, neighbors_left_next;

  function automatic record_t mk(logic [3:0] k, logic [7:0] t, logic [15:0] v,
      logic [31:0] w1, logic [31:0] w2, logic [31:0] l, logic [7:0] m,
      logic [7:0] th, logic [7:0] f, logic e);
    record_t r;
    r.record_kind = k; r.message_type = t; r.version_major = v[15:8];
    r.version_minor = v[7:0]; r.first_word = w1; r.second_word = w2;
    r.lifetime = l; r.metric = m; r.threshold = th; r.neighbor_flags = f;
    r.end_of_message = e;
    return r;
  endfunction

  always_comb begin
    logic [3:0] entry_len;
    logic [2:0] w;
    logic open_item;
    header_position_next = header_position;
    type_register_next = type_register;
    version_bytes_next = version_bytes;
    section_state_next = section_state;
    byte_in_group_next = byte_in_group;
    word_a_next = word_a;
    word_b_next = word_b;
    word_c_next = word_c;
    origin_width_next = origin_width;
    metric_byte_next = metric_byte;
    threshold_byte_next = threshold_byte;
    flags_byte_next = flags_byte;
    neighbors_left_next = neighbors_left;
    pair = '0;
    entry_len = (type_register == 8'd6) ? 4'd8 : 4'd7;
    w = 3'd1;
    case (section_state)
      S_HDR: begin
        if (header_position == 4'd0) begin
          type_register_next = '0;
          version_bytes_next = '0;
        end
        if (header_position == 4'd1) type_register_next = data_byte;
        if (header_position == 4'd6)
          version_bytes_next = {version_bytes_next[15:8], data_byte};
        if (header_position == 4'd7) begin
          version_bytes_next = {data_byte, version_bytes_next[7:0]};
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_HEADER, type_register_next, version_bytes_next,
                          '0, '0, '0, '0, '0, '0, 1'b0);
          header_position_next = '0;
          byte_in_group_next = '0;
          word_a_next = '0; word_b_next = '0; word_c_next = '0;
          case (type_register)
            8'd1: section_state_next = S_GENID;
            8'd2: section_state_next = S_MASK;
            8'd4, 8'd6: section_state_next = S_ENTRY;
            8'd7: section_state_next = S_PRUNE;
            8'd8, 8'd9: section_state_next = S_GRAFT;
            default: section_state_next = S_SKIP;
          endcase
        end else begin
          header_position_next = header_position + 4'd1;
        end
      end
      S_GENID: begin
        word_a_next = {word_a[23:0], data_byte};
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd3) begin
          byte_in_group_next = '0;
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_GENID, type_register, version_bytes, word_a_next,
                          '0, '0, '0, '0, '0, 1'b0);
          section_state_next = S_PNBR;
        end
      end
      S_PNBR: begin
        word_b_next = {word_b[23:0], data_byte};
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd3) begin
          byte_in_group_next = '0;
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_PNBR, type_register, version_bytes, word_a,
                          word_b_next, '0, '0, '0, '0, 1'b0);
        end
      end
      S_MASK: begin
        if (byte_in_group == 4'd0) begin
          word_a_next = {24'd0, data_byte} | 32'h0000_ff00;
          origin_width_next = 3'd1;
        end else begin
          word_a_next = {word_a[23:0], data_byte};
        end
        if (data_byte != 8'd0) origin_width_next = byte_in_group[2:0] + 3'd2;
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd2) begin
          byte_in_group_next = '0;
          word_b_next = '0;
          section_state_next = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        if ({1'b0, byte_in_group} < {2'b0, origin_width}) begin
          word_b_next = {word_b[23:0], data_byte};
          byte_in_group_next = byte_in_group + 4'd1;
        end else begin
          w = origin_width;
          if (w < 3'd1) w = 3'd1;
          if (w > 3'd4) w = 3'd4;
          metric_byte_next = data_byte;
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_ROUTE, type_register, version_bytes, word_a,
                          word_b << {(3'd4 - w), 3'd0}, '0,
                          {1'b0, data_byte[6:0]}, '0, '0, 1'b0);
          byte_in_group_next = '0;
          word_b_next = '0;
          if (data_byte[7]) section_state_next = S_MASK;
        end
      end
      S_ENTRY: begin
        if (byte_in_group < 4'd4) begin
          if (byte_in_group == 4'd0) flags_byte_next = '0;
          word_a_next = {word_a[23:0], data_byte};
        end else if (byte_in_group == 4'd4) begin
          metric_byte_next = data_byte;
        end else if (byte_in_group == 4'd5) begin
          threshold_byte_next = data_byte;
        end else if (byte_in_group == 4'd6 && entry_len == 4'd8) begin
          flags_byte_next = data_byte;
        end else begin
          neighbors_left_next = data_byte;
        end
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group_next >= entry_len) begin
          byte_in_group_next = '0;
          word_b_next = '0;
          if (neighbors_left_next != 8'd0) section_state_next = S_LIST;
        end
      end
      S_LIST: begin
        word_b_next = {word_b[23:0], data_byte};
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd3) begin
          byte_in_group_next = '0;
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_NBR, type_register, version_bytes, word_a,
                          word_b_next, '0, metric_byte, threshold_byte,
                          flags_byte, 1'b0);
          word_b_next = '0;
          neighbors_left_next = neighbors_left - 8'd1;
          if (neighbors_left == 8'd1) section_state_next = S_ENTRY;
        end
      end
      S_PRUNE: begin
        if (byte_in_group < 4'd4) word_a_next = {word_a[23:0], data_byte};
        else if (byte_in_group < 4'd8) word_b_next = {word_b[23:0], data_byte};
        else word_c_next = {word_c[23:0], data_byte};
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd11) begin
          byte_in_group_next = '0;
          pair.has_a = 1'b1;
          pair.rec_a = mk(KIND_PRUNE, type_register, version_bytes, word_a,
                          word_b, word_c_next, '0, '0, '0, 1'b0);
          section_state_next = S_DONE;
        end
      end
      S_GRAFT: begin
        if (byte_in_group < 4'd4) word_a_next = {word_a[23:0], data_byte};
        else word_b_next = {word_b[23:0], data_byte};
        byte_in_group_next = byte_in_group + 4'd1;
        if (byte_in_group == 4'd7) begin
          byte_in_group_next = '0;
          pair.has_a = 1'b1;
          pair.rec_a = mk((type_register == 8'd9) ? KIND_GACK : KIND_GRAFT,
                          type_register, version_bytes, word_a, word_b_next,
                          '0, '0, '0, '0, 1'b0);
          section_state_next = S_DONE;
        end
      end
      default: ;
    endcase
    if (last_byte) begin
      case (section_state_next)
        S_HDR, S_GENID, S_ORIGIN, S_LIST, S_PRUNE, S_GRAFT: open_item = 1'b1;
        S_PNBR, S_MASK, S_ENTRY: open_item = byte_in_group_next != 4'd0;
        default: open_item = 1'b0;
      endcase
      if (pair.has_a) begin
        pair.has_b = 1'b1;
        pair.rec_b = mk(open_item ? KIND_TRUNC : KIND_END, type_register_next,
                        version_bytes_next, '0, '0, '0, '0, '0, '0, 1'b1);
      end else begin
        pair.has_a = 1'b1;
        pair.rec_a = mk(open_item ? KIND_TRUNC : KIND_END, type_register_next,
                        version_bytes_next, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      section_state_next = S_HDR;
      header_position_next = '0;
      byte_in_group_next = '0;
      neighbors_left_next = '0;
    end else begin
      open_item = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0; type_register <= '0; version_bytes <= '0;
      section_state <= S_HDR; byte_in_group <= '0; word_a <= '0;
      word_b <= '0; word_c <= '0; origin_width <= 3'd1; metric_byte <= '0;
      threshold_byte <= '0; flags_byte <= '0; neighbors_left <= '0;
    end else if (take) begin
      header_position <= header_position_next;
      type_register <= type_register_next;
      version_bytes <= version_bytes_next;
      section_state <= section_state_next;
      byte_in_group <= byte_in_group_next;
      word_a <= word_a_next; word_b <= word_b_next; word_c <= word_c_next;
      origin_width <= origin_width_next;
      metric_byte <= metric_byte_next;
      threshold_byte <= threshold_byte_next;
      flags_byte <= flags_byte_next;
      neighbors_left <= neighbors_left_next;
    end
  end
endmodule

/* rtl/dvmrp_back.sv */
// Record queue: takes up to two records a cycle on write, hands out one a cycle on pop while not empty.
module dvmrp_back #(
  parameter int unsigned Depth = dvmrp_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                write,
  input  dvmrp_pkg::pair_t    pair,
  output logic                room,
  input  logic                pop,
  output logic                empty,
  output dvmrp_pkg::record_t  head
);
  import dvmrp_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  record_t mem [Depth];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [AW:0] count, count_next;
  logic do_pop;

  assign empty = (count == '0);
  assign do_pop = pop && !empty;
  // Hold two free slots so a two-record byte always fits.
  assign room = (count <= (AW+1)'(Depth - 2));
  assign head = mem[rd_ptr];

  always_comb begin
    count_next = count - {{AW{1'b0}}, do_pop};
    if (write) count_next = count_next + {{AW{1'b0}}, pair.has_a}
                                      + {{AW{1'b0}}, pair.has_b};
  end

  always_ff @(posedge clk) begin
    if (write && pair.has_a) mem[wr_ptr] <= pair.rec_a;
    if (write && pair.has_b) mem[AW'(wr_ptr + AW'(1))] <= pair.rec_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
    end else begin
      count <= count_next;
      if (do_pop) rd_ptr <= AW'(rd_ptr + AW'(1));
      if (write) wr_ptr <= AW'(wr_ptr + AW'({1'b0, pair.has_a} + {1'b0, pair.has_b}));
    end
  end
endmodule

/* rtl/dvmrp_message_parser_top.sv */
// Top level of the DVMRP message parser.
// A record caused by a byte is registered into the queue and shows on the result ports once at its head.
// Throughput: one byte a cycle while full is low; a byte may yield two records, drained one a cycle.
// Rate is set by the record queue, whose default depth (four) leaves room for two records.
// Reset: synchronous rst clears the parse state to the header phase and empties the queue.
module dvmrp_message_parser_top #(
  parameter int unsigned Depth = dvmrp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  record_kind,
  output logic [7:0]  message_type,
  output logic [7:0]  version_major,
  output logic [7:0]  version_minor,
  output logic [31:0] first_word,
  output logic [31:0] second_word,
  output logic [31:0] lifetime,
  output logic [7:0]  metric,
  output logic [7:0]  threshold,
  output logic [7:0]  neighbor_flags,
  output logic        end_of_message
);
  import dvmrp_pkg::*;

  pair_t   pair;
  record_t head;
  logic    room, take;

  // Accept a request only while the queue can absorb its worst case.
  assign full = !room;
  assign take = push && room;

  dvmrp_front u_front (
    .clk(clk), .rst(rst), .take(take), .data_byte(data_byte),
    .last_byte(last_byte), .pair(pair)
  );

  dvmrp_back #(.Depth(Depth)) u_back (
    .clk(clk), .rst(rst), .write(take), .pair(pair), .room(room),
    .pop(pop), .empty(empty), .head(head)
  );

  assign record_kind    = head.record_kind;
  assign message_type   = head.message_type;
  assign version_major  = head.version_major;
  assign version_minor  = head.version_minor;
  assign first_word     = head.first_word;
  assign second_word    = head.second_word;
  assign lifetime       = head.lifetime;
  assign metric         = head.metric;
  assign threshold      = head.threshold;
  assign neighbor_flags = head.neighbor_flags;
  assign end_of_message = head.end_of_message;
endmodule
